[src/mppag_pkg.sv]
`timescale 1ns / 1ps

package mppag_pkg;

    localparam int DIM_W      = 16;
    localparam int ADDR_W     = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int MODE_W     = 2;
    localparam int PW_W       = 6;

    // mode register bits
    localparam int MODE_ROW_MAJOR_BIT  = 0;
    localparam int MODE_COL_PANELS_BIT = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE,
        REG_SOURCE_BASE,
        REG_LEAD_DIM,
        REG_BLOCK_ROWS,
        REG_BLOCK_COLS,
        REG_PANEL_WIDTH,
        REG_ROW_OFFSET,
        REG_COL_OFFSET
    } cfg_idx_t;

    // settled view of the configuration shared by front and back
    typedef struct packed {
        logic              row_major;
        logic              col_panels;
        logic [ADDR_W-1:0] source_base;
        logic [DIM_W-1:0]  lead_dim;
        logic [DIM_W-1:0]  outer_dim;
        logic [DIM_W-1:0]  inner_dim;
        logic [DIM_W-1:0]  row_offset;
        logic [DIM_W-1:0]  col_offset;
    } cfg_t;

    // one packed position handed from front to back (lane travels beside it)
    typedef struct packed {
        logic [DIM_W-1:0] origin;
        logic [DIM_W-1:0] inner;
        logic             pad;
        logic             last;
    } pos_t;

endpackage

[src/matrix_panel_pack_address_gen_core.sv]
`timescale 1ns / 1ps

// Micro-panel packing address generator. Each input transaction (restart in
// s_tdata bit 0) yields one packed position on the output: destination index,
// source element address, pad flag and last flag. Sustained rate is one
// transaction per cycle while the output is not stalled. The walk position
// enters a two-entry queue at the accepting edge, then one multiply stage and
// one add stage form the index and address. The front
// side keeps taking transactions while the output is stalled until the queue
// holds two positions. Configuration is written through
// cfg_we/cfg_addr/cfg_wdata and must only change while idle.
module matrix_panel_pack_address_gen_core
    import mppag_pkg::*;
#(
    parameter int MAX_PANEL_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] restart
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,   // [31:0] dest_index, [63:32] src_addr
    output logic                  m_tuser,   // [0] pad
    output logic                  m_tlast
);

    localparam int LANE_W = (MAX_PANEL_WIDTH > 1) ? $clog2(MAX_PANEL_WIDTH) : 1;
    localparam int EW_W   = $clog2(MAX_PANEL_WIDTH + 1);
    localparam logic [7:0] MAX_PW8 = 8'(MAX_PANEL_WIDTH);
    localparam int Q_W    = $bits(pos_t) + LANE_W;

    logic [MODE_W-1:0] mode_reg;
    logic [ADDR_W-1:0] source_base_reg;
    logic [DIM_W-1:0]  lead_dim_reg;
    logic [DIM_W-1:0]  block_rows_reg;
    logic [DIM_W-1:0]  block_cols_reg;
    logic [PW_W-1:0]   panel_width_reg;
    logic [DIM_W-1:0]  row_offset_reg;
    logic [DIM_W-1:0]  col_offset_reg;

    cfg_t              cfg;
    logic [EW_W-1:0]   eff_w;
    logic [DIM_W-1:0]  rows_eff, cols_eff;
    logic [7:0]        pw8;

    logic              q_full, q_push, q_valid, q_pop;
    pos_t              f_pos, b_pos;
    logic [LANE_W-1:0] f_lane, b_lane;
    logic [Q_W-1:0]    q_rd_data;
    logic [ADDR_W-1:0] dest_index, src_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= '0;
            source_base_reg <= '0;
            lead_dim_reg    <= DIM_W'(1);
            block_rows_reg  <= DIM_W'(1);
            block_cols_reg  <= DIM_W'(1);
            panel_width_reg <= PW_W'(4);
            row_offset_reg  <= '0;
            col_offset_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_MODE:        mode_reg        <= cfg_wdata[MODE_W-1:0];
                REG_SOURCE_BASE: source_base_reg <= cfg_wdata[ADDR_W-1:0];
                REG_LEAD_DIM:    lead_dim_reg    <= cfg_wdata[DIM_W-1:0];
                REG_BLOCK_ROWS:  block_rows_reg  <= cfg_wdata[DIM_W-1:0];
                REG_BLOCK_COLS:  block_cols_reg  <= cfg_wdata[DIM_W-1:0];
                REG_PANEL_WIDTH: panel_width_reg <= cfg_wdata[PW_W-1:0];
                REG_ROW_OFFSET:  row_offset_reg  <= cfg_wdata[DIM_W-1:0];
                REG_COL_OFFSET:  col_offset_reg  <= cfg_wdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        pw8 = 8'(panel_width_reg);
        if (pw8 == 8'd0) begin
            eff_w = EW_W'(1);
        end else if (pw8 > MAX_PW8) begin
            eff_w = EW_W'(MAX_PW8);
        end else begin
            eff_w = EW_W'(pw8);
        end

        rows_eff = (block_rows_reg == '0) ? DIM_W'(1) : block_rows_reg;
        cols_eff = (block_cols_reg == '0) ? DIM_W'(1) : block_cols_reg;

        cfg.row_major   = mode_reg[MODE_ROW_MAJOR_BIT];
        cfg.col_panels  = mode_reg[MODE_COL_PANELS_BIT];
        cfg.source_base = source_base_reg;
        cfg.lead_dim    = lead_dim_reg;
        cfg.outer_dim   = cfg.col_panels ? cols_eff : rows_eff;
        cfg.inner_dim   = cfg.col_panels ? rows_eff : cols_eff;
        cfg.row_offset  = row_offset_reg;
        cfg.col_offset  = col_offset_reg;
    end

    mppag_front #(
        .LANE_W (LANE_W),
        .EW_W   (EW_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .eff_w    (eff_w),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .restart  (s_tdata[0]),
        .q_full   (q_full),
        .push     (q_push),
        .pos      (f_pos),
        .pos_lane (f_lane)
    );

    mppag_fifo #(
        .DATA_W (Q_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_push),
        .wr_data  ({f_lane, f_pos}),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_en    (q_pop),
        .rd_data  (q_rd_data)
    );

    assign b_pos  = q_rd_data[$bits(pos_t)-1:0];
    assign b_lane = q_rd_data[Q_W-1:$bits(pos_t)];

    mppag_back #(
        .LANE_W (LANE_W),
        .EW_W   (EW_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .eff_w      (eff_w),
        .q_valid    (q_valid),
        .q_pos      (b_pos),
        .q_lane     (b_lane),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .dest_index (dest_index),
        .src_addr   (src_addr),
        .pad        (m_tuser),
        .last       (m_tlast)
    );

    assign m_tdata = {src_addr, dest_index};

endmodule

[src/mppag_front.sv]
`timescale 1ns / 1ps

module mppag_front
    import mppag_pkg::*;
#(
    parameter int LANE_W = 5,
    parameter int EW_W   = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic [EW_W-1:0]   eff_w,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              restart,
    input  logic              q_full,
    output logic              push,
    output pos_t              pos,
    output logic [LANE_W-1:0] pos_lane
);

    logic [DIM_W-1:0]  origin_reg, origin_next;
    logic [DIM_W-1:0]  inner_reg, inner_next;
    logic [LANE_W-1:0] lane_reg, lane_next;

    logic [DIM_W-1:0]  origin_cur;
    logic [DIM_W-1:0]  inner_cur;
    logic [LANE_W-1:0] lane_cur;
    logic [DIM_W:0]    pidx;
    logic [EW_W:0]     lane_inc;
    logic [DIM_W:0]    inner_inc;
    logic [DIM_W:0]    origin_step;
    logic              lane_end, inner_end, panel_end;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    always_comb begin
        origin_cur  = restart ? '0 : origin_reg;
        inner_cur   = restart ? '0 : inner_reg;
        lane_cur    = restart ? '0 : lane_reg;

        pidx        = {1'b0, origin_cur} + (DIM_W+1)'(lane_cur);
        lane_inc    = (EW_W+1)'(lane_cur) + (EW_W+1)'(1);
        inner_inc   = {1'b0, inner_cur} + (DIM_W+1)'(1);
        origin_step = {1'b0, origin_cur} + (DIM_W+1)'(eff_w);

        lane_end    = lane_inc >= {1'b0, eff_w};
        inner_end   = inner_inc >= {1'b0, cfg.inner_dim};
        panel_end   = origin_step >= {1'b0, cfg.outer_dim};

        pos.origin  = origin_cur;
        pos.inner   = inner_cur;
        pos.pad     = pidx >= {1'b0, cfg.outer_dim};
        pos.last    = lane_end && inner_end && panel_end;
        pos_lane    = lane_cur;

        // lane first, then inner, then panel
        origin_next = origin_cur;
        inner_next  = inner_cur;
        lane_next   = lane_cur;
        if (!lane_end) begin
            lane_next = lane_inc[LANE_W-1:0];
        end else begin
            lane_next = '0;
            if (!inner_end) begin
                inner_next = inner_inc[DIM_W-1:0];
            end else begin
                inner_next  = '0;
                origin_next = panel_end ? '0 : origin_step[DIM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg <= '0;
            inner_reg  <= '0;
            lane_reg   <= '0;
        end else if (push) begin
            origin_reg <= origin_next;
            inner_reg  <= inner_next;
            lane_reg   <= lane_next;
        end
    end

    // the final position of a block always wraps the walk to the start
    a_wrap_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && pos.last) |=> (origin_reg == '0 && inner_reg == '0 && lane_reg == '0))
        else $error("walk did not wrap after last position");

endmodule

[src/mppag_fifo.sv]
`timescale 1ns / 1ps

module mppag_fifo #(
    parameter int DATA_W = 40
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    output logic              full,
    output logic              rd_valid,
    input  logic              rd_en,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg, count_next;
    logic              do_wr, do_rd;

    assign full     = count_reg == 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb begin
        count_next = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + 2'd1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (do_wr) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count overflow");

    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers out of step with count");

endmodule

[src/mppag_back.sv]
`timescale 1ns / 1ps

module mppag_back
    import mppag_pkg::*;
#(
    parameter int LANE_W = 5,
    parameter int EW_W   = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic [EW_W-1:0]   eff_w,
    input  logic              q_valid,
    input  pos_t              q_pos,
    input  logic [LANE_W-1:0] q_lane,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ADDR_W-1:0] dest_index,
    output logic [ADDR_W-1:0] src_addr,
    output logic              pad,
    output logic              last
);

    localparam int OFF_W = DIM_W + EW_W + 1;

    logic adv_out, adv_a;

    // stage A: products
    logic                a_valid_reg;
    logic [ADDR_W-1:0]   a_dest_prod_reg;
    logic [OFF_W-1:0]    a_lane_off_reg;
    logic [ADDR_W-1:0]   a_addr_prod_reg;
    logic [ADDR_W-1:0]   a_base_reg;
    logic                a_pad_reg;
    logic                a_last_reg;

    logic [DIM_W:0]      pidx;
    logic [DIM_W:0]      row, col;
    logic [DIM_W+1:0]    r, c, mul_a, add_b;
    logic [DIM_W*2+1:0]  addr_prod;
    logic [ADDR_W-1:0]   dest_prod;
    logic [OFF_W-1:0]    lane_off;

    // output stage
    logic                out_valid_reg;
    logic [ADDR_W-1:0]   dest_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                pad_reg;
    logic                last_reg;

    assign adv_out = !out_valid_reg || out_ready;
    assign adv_a   = !a_valid_reg || adv_out;
    assign q_pop   = q_valid && adv_a;

    always_comb begin
        pidx  = {1'b0, q_pos.origin} + (DIM_W+1)'(q_lane);
        row   = cfg.col_panels ? {1'b0, q_pos.inner} : pidx;
        col   = cfg.col_panels ? pidx : {1'b0, q_pos.inner};
        r     = (DIM_W+2)'(cfg.row_offset) + (DIM_W+2)'(row);
        c     = (DIM_W+2)'(cfg.col_offset) + (DIM_W+2)'(col);
        mul_a = cfg.row_major ? r : c;
        add_b = cfg.row_major ? c : r;
        addr_prod = mul_a * cfg.lead_dim;
        dest_prod = q_pos.origin * cfg.inner_dim;
        lane_off  = q_pos.inner * eff_w + OFF_W'(q_lane);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv_a) begin
                a_valid_reg <= q_valid;
            end
            if (adv_out) begin
                out_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_a) begin
            a_dest_prod_reg <= dest_prod;
            a_lane_off_reg  <= lane_off;
            a_addr_prod_reg <= addr_prod[ADDR_W-1:0];
            a_base_reg      <= cfg.source_base + ADDR_W'(add_b);
            a_pad_reg       <= q_pos.pad;
            a_last_reg      <= q_pos.last;
        end
        if (adv_out) begin
            dest_reg <= a_dest_prod_reg + ADDR_W'(a_lane_off_reg);
            addr_reg <= a_pad_reg ? '0 : a_addr_prod_reg + a_base_reg;
            pad_reg  <= a_pad_reg;
            last_reg <= a_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign dest_index = dest_reg;
    assign src_addr   = addr_reg;
    assign pad        = pad_reg;
    assign last       = last_reg;

    // a product waiting on a stalled output must not be overwritten
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && !adv_out) |=> (a_valid_reg && $stable(a_addr_prod_reg)
                                       && $stable(a_dest_prod_reg)))
        else $error("stage A lost a transaction under back-pressure");

endmodule
